// ===== rtl/espivw_pkg.sv =====
package espivw_pkg;

  localparam int STORE_DEPTH     = 14;
  localparam int SLOT_W          = 4;
  localparam int WATCH_MAX       = 8;
  localparam int WPOS_W          = 3;
  localparam int SIGNAL_COUNT    = 23;
  localparam int SIG_W           = 5;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DEFAULT_WATCHED = 8;
  localparam int IN_W            = 24;
  localparam int OUT_W           = 16;

  typedef enum logic [1:0] {
    CMD_HOST_WRITE = 2'd0,
    CMD_SET_WIRE   = 2'd1,
    CMD_GET_WIRE   = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SLOT_02 = 4'd0;
  localparam slot_t SLOT_03 = 4'd1;
  localparam slot_t SLOT_04 = 4'd2;
  localparam slot_t SLOT_05 = 4'd3;
  localparam slot_t SLOT_06 = 4'd4;
  localparam slot_t SLOT_07 = 4'd5;
  localparam slot_t SLOT_40 = 4'd6;
  localparam slot_t SLOT_41 = 4'd7;
  localparam slot_t SLOT_42 = 4'd8;

  localparam logic [7:0] PLTRST_LVL       = 8'h02;
  localparam logic [7:0] PLTRST_VLD       = 8'h20;
  localparam logic [7:0] OOB_WARN_LVL     = 8'h04;
  localparam logic [7:0] OOB_WARN_VLD     = 8'h40;
  localparam logic [7:0] HOST_WARN_LVL    = 8'h01;
  localparam logic [7:0] HOST_WARN_VLD    = 8'h10;
  localparam logic [7:0] SUS_WARN_LVL     = 8'h01;
  localparam logic [7:0] SUS_WARN_VLD     = 8'h10;
  localparam logic [7:0] HOST_STARTUP_VAL = 8'hFF;
  localparam int         OOB_ACK_BIT      = 0;
  localparam int         HOST_ACK_BIT     = 3;
  localparam int         SUS_ACK_BIT      = 0;

  typedef struct packed {
    slot_t      slot;
    logic [7:0] lvl;
    logic [7:0] vld;
  } wire_def_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              ok;
    slot_t             slot;
    logic [7:0]        value;
    logic [7:0]        lvl_mask;
    logic [7:0]        vld_mask;
    logic              level_in;
    logic              watched;
    logic [WPOS_W-1:0] wpos;
  } item_t;

  function automatic logic in_store(input logic [7:0] idx);
    in_store = ((idx >= 8'h02) && (idx <= 8'h07)) || ((idx >= 8'h40) && (idx <= 8'h47));
  endfunction

  function automatic slot_t slot_of(input logic [7:0] idx);
    if (idx[6]) begin
      slot_of = idx[SLOT_W-1:0] + 4'd6;
    end else begin
      slot_of = idx[SLOT_W-1:0] - 4'd2;
    end
  endfunction

  function automatic logic [7:0] watch_index(input logic [WPOS_W-1:0] pos);
    case (pos)
      3'd0:    watch_index = 8'h02;
      3'd1:    watch_index = 8'h03;
      3'd2:    watch_index = 8'h07;
      3'd3:    watch_index = 8'h41;
      3'd4:    watch_index = 8'h42;
      3'd5:    watch_index = 8'h43;
      3'd6:    watch_index = 8'h44;
      default: watch_index = 8'h47;
    endcase
  endfunction

  function automatic logic [7:0] reset_byte(input slot_t slot);
    case (slot)
      SLOT_04: reset_byte = 8'h10;
      SLOT_05: reset_byte = 8'h99;
      SLOT_40: reset_byte = 8'h10;
      default: reset_byte = 8'h00;
    endcase
  endfunction

  function automatic wire_def_t wire_def(input logic [SIG_W-1:0] sig);
    case (sig)
      5'd0:    wire_def = '{SLOT_02, 8'h01, 8'h10};
      5'd1:    wire_def = '{SLOT_02, 8'h02, 8'h20};
      5'd2:    wire_def = '{SLOT_02, 8'h04, 8'h40};
      5'd3:    wire_def = '{SLOT_03, 8'h01, 8'h10};
      5'd4:    wire_def = '{SLOT_03, 8'h02, 8'h20};
      5'd5:    wire_def = '{SLOT_03, 8'h04, 8'h40};
      5'd6:    wire_def = '{SLOT_04, 8'h01, 8'h10};
      5'd7:    wire_def = '{SLOT_04, 8'h04, 8'h40};
      5'd8:    wire_def = '{SLOT_04, 8'h08, 8'h80};
      5'd9:    wire_def = '{SLOT_05, 8'h02, 8'h20};
      5'd10:   wire_def = '{SLOT_05, 8'h04, 8'h40};
      5'd11:   wire_def = '{SLOT_05, 8'h09, 8'h90};
      5'd12:   wire_def = '{SLOT_06, 8'h01, 8'h10};
      5'd13:   wire_def = '{SLOT_06, 8'h02, 8'h20};
      5'd14:   wire_def = '{SLOT_06, 8'h04, 8'h40};
      5'd15:   wire_def = '{SLOT_06, 8'h08, 8'h80};
      5'd16:   wire_def = '{SLOT_07, 8'h01, 8'h10};
      5'd17:   wire_def = '{SLOT_40, 8'h01, 8'h10};
      5'd18:   wire_def = '{SLOT_41, 8'h01, 8'h10};
      5'd19:   wire_def = '{SLOT_41, 8'h02, 8'h20};
      5'd20:   wire_def = '{SLOT_41, 8'h08, 8'h80};
      5'd21:   wire_def = '{SLOT_42, 8'h01, 8'h10};
      5'd22:   wire_def = '{SLOT_42, 8'h02, 8'h20};
      default: wire_def = '{SLOT_02, 8'h00, 8'h00};
    endcase
  endfunction

endpackage

// ===== rtl/espivw_front.sv =====
module espivw_front #(
  parameter int WATCHED_INDICES = espivw_pkg::DEFAULT_WATCHED
) (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [espivw_pkg::IN_W-1:0] in_tdata,
  input  logic                        q_full,
  output logic                        push,
  output espivw_pkg::item_t           item
);

  logic [1:0]                   f_cmd;
  logic [7:0]                   f_index;
  logic [espivw_pkg::SIG_W-1:0] f_sig;
  espivw_pkg::wire_def_t        wd;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  assign f_cmd   = in_tdata[1:0];
  assign f_index = in_tdata[9:2];
  assign f_sig   = in_tdata[22:18];
  assign wd      = espivw_pkg::wire_def(f_sig);

  always_comb begin
    item          = '0;
    item.cmd      = espivw_pkg::cmd_t'(f_cmd);
    item.value    = in_tdata[17:10];
    item.level_in = in_tdata[23];
    case (item.cmd)
      espivw_pkg::CMD_SET_WIRE, espivw_pkg::CMD_GET_WIRE: begin
        item.ok       = f_sig < espivw_pkg::SIG_W'(espivw_pkg::SIGNAL_COUNT);
        item.slot     = wd.slot;
        item.lvl_mask = wd.lvl;
        item.vld_mask = wd.vld;
      end
      default: begin
        item.ok   = espivw_pkg::in_store(f_index);
        item.slot = espivw_pkg::slot_of(f_index);
      end
    endcase
    // watch list entries are distinct, so at most one position matches
    for (int i = 0; i < espivw_pkg::WATCH_MAX; i++) begin
      if ((i < WATCHED_INDICES) && (item.cmd == espivw_pkg::CMD_HOST_WRITE) &&
          (espivw_pkg::watch_index(espivw_pkg::WPOS_W'(i)) == f_index)) begin
        item.watched = 1'b1;
        item.wpos    = espivw_pkg::WPOS_W'(i);
      end
    end
  end

endmodule

// ===== rtl/espivw_queue.sv =====
module espivw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  espivw_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output espivw_pkg::item_t head,
  output logic              empty
);

  localparam int DEPTH = espivw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  espivw_pkg::item_t slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_nxt;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/espivw_back.sv =====
module espivw_back #(
  parameter int WATCHED_INDICES = espivw_pkg::DEFAULT_WATCHED
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  espivw_pkg::item_t            head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [espivw_pkg::OUT_W-1:0] out_tdata
);

  localparam int WIW = (WATCHED_INDICES > 1) ? $clog2(WATCHED_INDICES) : 1;

  espivw_pkg::back_state_t      state_r;
  espivw_pkg::back_state_t      state_nxt;
  espivw_pkg::item_t            cur_r;
  logic [7:0]                   byte_r;
  logic [7:0]                   snap_byte_r;
  logic [7:0]                   store_r   [espivw_pkg::STORE_DEPTH];
  logic [7:0]                   store_nxt [espivw_pkg::STORE_DEPTH];
  logic [7:0]                   snap_r    [WATCHED_INDICES];
  logic                         out_tvalid_r;
  logic [espivw_pkg::OUT_W-1:0] out_tdata_r;
  logic                         out_free;
  logic                         exec;
  logic                         snap_we;
  logic [7:0]                   chg;
  logic [7:0]                   set_byte;
  logic                         res_level;
  logic [7:0]                   res_read;
  logic                         res_perr;
  logic [2:0]                   res_sleep;
  logic                         res_p80;
  logic                         res_start;

  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      espivw_pkg::BK_IDLE: begin
        if (!empty) begin
          state_nxt = espivw_pkg::BK_EXEC;
        end
      end
      espivw_pkg::BK_EXEC: begin
        if (out_free) begin
          state_nxt = espivw_pkg::BK_IDLE;
        end
      end
      default: state_nxt = espivw_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    exec = 1'b0;
    case (state_r)
      espivw_pkg::BK_IDLE: pop  = !empty;
      espivw_pkg::BK_EXEC: exec = out_free;
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < espivw_pkg::STORE_DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end
    snap_we   = 1'b0;
    chg       = snap_byte_r ^ cur_r.value;
    set_byte  = cur_r.level_in ? (byte_r | cur_r.lvl_mask) : (byte_r & ~cur_r.lvl_mask);
    res_level = 1'b0;
    res_read  = '0;
    res_perr  = !cur_r.ok;
    res_sleep = '0;
    res_p80   = 1'b0;
    res_start = 1'b0;
    case (cur_r.cmd)
      espivw_pkg::CMD_HOST_WRITE: begin
        if (cur_r.ok) begin
          store_nxt[cur_r.slot] = cur_r.value;
          if (cur_r.watched) begin
            snap_we = 1'b1;
            case (cur_r.slot)
              espivw_pkg::SLOT_02: res_sleep = chg[2:0];
              espivw_pkg::SLOT_03: begin
                // platform reset edge first, then oob ack follows its warning
                if (chg[1]) begin
                  if (|(cur_r.value & espivw_pkg::PLTRST_VLD) &&
                      |(cur_r.value & espivw_pkg::PLTRST_LVL)) begin
                    store_nxt[espivw_pkg::SLOT_06] = espivw_pkg::HOST_STARTUP_VAL;
                    res_start = 1'b1;
                  end else begin
                    res_p80 = 1'b1;
                  end
                end
                if (chg[2]) begin
                  store_nxt[espivw_pkg::SLOT_04][espivw_pkg::OOB_ACK_BIT] =
                    |(cur_r.value & espivw_pkg::OOB_WARN_VLD) &&
                    |(cur_r.value & espivw_pkg::OOB_WARN_LVL);
                end
              end
              espivw_pkg::SLOT_07: begin
                if (chg[0]) begin
                  store_nxt[espivw_pkg::SLOT_06][espivw_pkg::HOST_ACK_BIT] =
                    |(cur_r.value & espivw_pkg::HOST_WARN_VLD) &&
                    |(cur_r.value & espivw_pkg::HOST_WARN_LVL);
                end
              end
              espivw_pkg::SLOT_41: begin
                if (chg[0]) begin
                  store_nxt[espivw_pkg::SLOT_40][espivw_pkg::SUS_ACK_BIT] =
                    |(cur_r.value & espivw_pkg::SUS_WARN_VLD) &&
                    |(cur_r.value & espivw_pkg::SUS_WARN_LVL);
                end
              end
              default: ;
            endcase
          end
        end
      end
      espivw_pkg::CMD_SET_WIRE: begin
        if (cur_r.ok) begin
          store_nxt[cur_r.slot] = set_byte;
        end
      end
      espivw_pkg::CMD_GET_WIRE: begin
        res_level = cur_r.ok && |(byte_r & cur_r.vld_mask) && |(byte_r & cur_r.lvl_mask);
      end
      default: begin
        res_read = cur_r.ok ? byte_r : 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= espivw_pkg::BK_IDLE;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < espivw_pkg::STORE_DEPTH; i++) begin
        store_r[i] <= espivw_pkg::reset_byte(espivw_pkg::SLOT_W'(i));
      end
      for (int i = 0; i < WATCHED_INDICES; i++) begin
        snap_r[i] <= espivw_pkg::reset_byte(espivw_pkg::slot_of(
                       espivw_pkg::watch_index(espivw_pkg::WPOS_W'(i))));
      end
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        out_tvalid_r <= 1'b1;
        for (int i = 0; i < espivw_pkg::STORE_DEPTH; i++) begin
          store_r[i] <= store_nxt[i];
        end
        if (snap_we) begin
          snap_r[cur_r.wpos[WIW-1:0]] <= cur_r.value;
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r       <= head;
      byte_r      <= head.ok ? store_r[head.slot] : 8'h00;
      snap_byte_r <= snap_r[head.wpos[WIW-1:0]];
    end
    if (exec) begin
      out_tdata_r <= {1'b0, res_start, res_p80, res_sleep, res_perr, res_read, res_level};
    end
  end

endmodule

// ===== rtl/espi_virtual_wire_responder_core.sv =====
// espi virtual wire responder core
// holds the slave side virtual wire bytes for indices 02h-07h and 40h-47h
// plus a change snapshot of the watched indices
// in_* channel: one request per handshake (command, index, value, signal, level)
//   command 0 host write, 1 set wire, 2 get wire, 3 raw byte read
// out_* channel: exactly one result per request, in request order
// a front stage classifies each request (store slot, wire masks, watch slot)
// and queues it two deep; a back engine reads the addressed byte as it pops
// the request in its idle state and writes back the store, snapshot and
// result register in its exec state
// the back engine finishes each request before it pops the next one
// a result waiting on out_tready stalls the back engine; the front keeps
// taking requests until the queue holds two
// reset loads the store with its power-on bytes and the snapshot with the
// watched bytes, empties the queue and drops out_tvalid
module espi_virtual_wire_responder_core #(
  parameter int WATCHED_INDICES = espivw_pkg::DEFAULT_WATCHED
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // command[1:0], wire_index[9:2], vw_value[17:10], signal_id[22:18], wire_level_in[23]
  input  logic [espivw_pkg::IN_W-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // wire_level[0], read_value[8:1], param_error[9], sleep_event_mask[12:10],
  // port80_reset_event[13], host_startup_applied[14], zero[15]
  output logic [espivw_pkg::OUT_W-1:0] out_tdata
);

  espivw_pkg::item_t push_item;
  espivw_pkg::item_t head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;

  espivw_front #(
    .WATCHED_INDICES(WATCHED_INDICES)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  espivw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  espivw_back #(
    .WATCHED_INDICES(WATCHED_INDICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// ===== rtl/espivw_checker.sv =====
module espivw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [espivw_pkg::OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[15])
    else $error("result pad bit set");

  a_reset_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[13] && out_tdata[14]))
    else $error("port80 reset and host startup in one result");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[8:1] != 8'h00) |->
      !out_tdata[0] && (out_tdata[12:10] == 3'b000) && !out_tdata[13] && !out_tdata[14])
    else $error("read result carries other command fields");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind espi_virtual_wire_responder_core espivw_checker u_espivw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
